>>> sv/fprm_pkg.sv
`timescale 1ns / 1ps
// fprm_pkg: request and response types, sequencer states and square root constants
// for the frame peak and rms meter. No dependencies.
package fprm_pkg;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               has_sample;
      logic               frame_end;
   } fprm_req_type;

   typedef struct packed {
      logic [15:0] peak_level;
      logic [15:0] rms_level;
   } fprm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } fprm_state_type;

   // magnitude, square and root widths follow from the 16-bit sample
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 31;
   localparam int SQRT_W     = 31;
   localparam int ROOT_W     = 32;
   localparam int SUB_W      = 33;
   localparam int SQRT_STEPS = 16;
   localparam logic [SQRT_W-1:0] SQRT_TOP = 31'h4000_0000;

endpackage

>>> sv/frame_peak_rms_meter.sv
`timescale 1ns / 1ps
// frame_peak_rms_meter: peak and rms level of one audio frame, with a shared
// subtractor that runs a restoring divide and then a bitwise square root.
// Depends on fprm_pkg.
//
// channel  direction  handshake                  payload
// req      in         req_valid / req_stall      fprm_req_type (sample, has_sample, frame_end)
// rsp      out        rsp_valid / rsp_stall      fprm_rsp_type (peak_level, rms_level)
//
// A request without frame_end is accepted in ST_IDLE; samples stream at one per cycle
// while no frame is closing. A request with frame_end steps in order: accept, fold
// the last square into the sum, SUM_W divide steps and 16 root steps on the one
// shared subtractor, load the output register. A frame with no samples skips the
// divide. Synchronous reset clears state, peak, sum, count, add_pend and rsp_valid.
// The result waits in its output register, so new requests are taken while rsp_stall
// holds it; only a second finished result waits for the first to leave.
module frame_peak_rms_meter
   import fprm_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  fprm_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output fprm_rsp_type rsp_data
);

   localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = COUNT_W + 30;
   localparam int STEP_W  = $clog2(SUM_W);

   fprm_state_type state_ff, state_in;

   logic [MAG_W-1:0]   peak_ff, peak_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic               add_pend_ff, add_pend_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SQRT_W-1:0]  m_ff, m_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SQRT_W-1:0]  bit_ff, bit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fprm_rsp_type       rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               take;
   logic               load_rsp;
   logic [16:0]        ext;
   logic [16:0]        mag17;
   logic [MAG_W-1:0]   mag;
   logic [31:0]        prod;
   logic [SUM_W-1:0]   sum_added;
   logic [COUNT_W:0]   div_trial;
   logic [ROOT_W-1:0]  root_trial;
   logic [SUB_W-1:0]   sub_a, sub_b, sub_diff;
   logic               sub_ge;
   logic               qbit;

   assign accept = req_valid && !req_stall;
   assign take   = accept && req_data.has_sample && (count_ff < COUNT_W'(MAX_SAMPLES));

   // magnitude of the sample, widened first so the most negative value gives 32768
   assign ext   = {req_data.sample[15], req_data.sample};
   assign mag17 = req_data.sample[15] ? (~ext + 17'd1) : ext;
   assign mag   = mag17[MAG_W-1:0];
   assign prod  = 32'(mag) * 32'(mag);

   assign sum_added = add_pend_ff ? (sum_ff + SUM_W'(sq_ff)) : sum_ff;

   assign div_trial  = {rem_ff, sum_ff[SUM_W-1]};
   assign root_trial = root_ff + ROOT_W'(bit_ff);

   // shared subtractor: divide trial in ST_DIV, root trial in ST_SQRT
   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_a = SUB_W'(m_ff);
         sub_b = SUB_W'(root_trial);
      end else begin
         sub_a = SUB_W'(div_trial);
         sub_b = SUB_W'(count_ff);
      end
      sub_diff = sub_a - sub_b;
      sub_ge   = !sub_diff[SUB_W-1];
   end

   assign qbit = sub_ge;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.frame_end) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (count_ff == '0) state_in = ST_SQRT;
            else                state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (step_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_DONE: load_rsp  = !rsp_valid_ff || !rsp_stall;
         ST_FOLD, ST_DIV, ST_SQRT: req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      peak_in     = peak_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      sq_in       = sq_ff;
      add_pend_in = add_pend_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      m_in        = m_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            // square registered here, folded into the sum on the next cycle
            sum_in      = sum_added;
            add_pend_in = take;
            if (take) begin
               sq_in    = prod[SQ_W-1:0];
               count_in = count_ff + COUNT_W'(1);
               if (mag > peak_ff) peak_in = mag;
            end
         end
         ST_FOLD: begin
            sum_in      = sum_added;
            add_pend_in = 1'b0;
            rem_in      = '0;
            if (count_ff == '0) begin
               m_in    = '0;
               root_in = '0;
               bit_in  = SQRT_TOP;
               step_in = STEP_W'(SQRT_STEPS - 1);
            end else begin
               step_in = STEP_W'(SUM_W - 1);
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? sub_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
            sum_in  = {sum_ff[SUM_W-2:0], qbit};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               // mean is at most 2^30, so the low bits hold all of it
               m_in    = sum_in[SQRT_W-1:0];
               root_in = '0;
               bit_in  = SQRT_TOP;
               step_in = STEP_W'(SQRT_STEPS - 1);
            end
         end
         ST_SQRT: begin
            if (sub_ge) begin
               m_in    = sub_diff[SQRT_W-1:0];
               root_in = (root_ff >> 1) + ROOT_W'(bit_ff);
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff - STEP_W'(1);
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.peak_level = peak_ff;
               rsp_data_in.rms_level  = root_ff[15:0];
               peak_in                = '0;
               sum_in                 = '0;
               count_in               = '0;
            end
         end
         default: begin
            add_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         peak_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         add_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         add_pend_ff  <= add_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      m_ff        <= m_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sample count never passes the saturation limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SAMPLES))
      else $error("sample count above limit");

   // closing request always starts the fold step
   a_close_fold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.frame_end) |=> state_ff == ST_FOLD)
      else $error("frame end did not start fold");

   // last square must be folded before divide and root use the sum
   a_fold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_SQRT) |-> !add_pend_ff)
      else $error("pending square not folded");

   // root of a mean up to 2^30 never exceeds 32768
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> root_ff <= ROOT_W'(32768))
      else $error("root out of range");

endmodule
